@@ src/sll_pkg.sv @@
// Shared constants, types and helpers of the static linked list engine.
package sll_pkg;

    localparam int NODE_COUNT = 64;
    localparam int IDX_W      = $clog2(NODE_COUNT);
    localparam int CNT_W      = $clog2(NODE_COUNT - 1);
    localparam int VAL_W      = 32;
    localparam int CMD_W      = 3;
    localparam int IDX_OUT_W  = 6;
    localparam int LEN_OUT_W  = 6;
    localparam int WIDE_W     = (IDX_W > IDX_OUT_W) ? IDX_W : IDX_OUT_W;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [CNT_W-1:0] t_cnt;
    typedef logic [VAL_W-1:0] t_val;
    typedef logic [CMD_W-1:0] t_cmd_code;

    localparam t_idx NODE_HEAD  = t_idx'(0);
    localparam t_idx NODE_FREE  = t_idx'(1);
    localparam t_idx NODE_FIRST = t_idx'(2);
    localparam t_idx NODE_LAST  = t_idx'(NODE_COUNT - 1);

    localparam t_cmd_code CMD_INS_HEAD = t_cmd_code'(0);
    localparam t_cmd_code CMD_INS_TAIL = t_cmd_code'(1);
    localparam t_cmd_code CMD_DELETE   = t_cmd_code'(2);
    localparam t_cmd_code CMD_SEARCH   = t_cmd_code'(3);
    localparam t_cmd_code CMD_CLEAR    = t_cmd_code'(4);

    typedef struct packed {
        logic start;
        logic from_free;
        logic clear;
        logic take_head;
        logic take_tail;
        logic advance;
        logic tail_link;
        logic unlink;
        logic relink;
        logic set_found;
        logic report;
    } t_dp_cmd;

    typedef struct packed {
        logic full;
        logic empty;
        logic last;
        logic match;
        logic prev_zero;
        logic out_busy;
    } t_dp_sts;

    function automatic t_idx reset_link(input t_idx idx);
        t_idx res;
        if (idx == NODE_LAST) begin
            res = NODE_FREE;
        end else if (idx == NODE_HEAD) begin
            res = NODE_HEAD;
        end else begin
            res = idx + t_idx'(1);
        end
        return res;
    endfunction

endpackage

@@ src/sll_ctrl.sv @@
// Command sequencer of the static linked list engine.
module sll_ctrl
    import sll_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_cmd_code i_command,
    output logic      o_in_stall,
    output t_dp_cmd   o_cmd,
    input  t_dp_sts   i_sts
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_TAKE   = 5'b00010,
        S_WALK   = 5'b00100,
        S_RELINK = 5'b01000,
        S_REPORT = 5'b10000
    } t_state;

    t_state    r_state, n_state;
    t_cmd_code r_cmd, n_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cmd   <= CMD_INS_HEAD;
        end else begin
            r_state <= n_state;
            r_cmd   <= n_cmd;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        n_cmd   = r_cmd;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd       = i_command;
                    o_cmd.start = 1'b1;
                    if (i_command == CMD_INS_HEAD || i_command == CMD_INS_TAIL) begin
                        o_cmd.from_free = 1'b1;
                        n_state = i_sts.full ? S_REPORT : S_TAKE;
                    end else if (i_command == CMD_DELETE || i_command == CMD_SEARCH) begin
                        n_state = i_sts.empty ? S_REPORT : S_WALK;
                    end else if (i_command == CMD_CLEAR) begin
                        o_cmd.clear = 1'b1;
                        n_state = S_REPORT;
                    end else begin
                        n_state = S_REPORT;
                    end
                end
            end
            S_TAKE: begin
                if (r_cmd == CMD_INS_HEAD) begin
                    o_cmd.take_head = 1'b1;
                    n_state = S_REPORT;
                end else begin
                    o_cmd.take_tail = 1'b1;
                    n_state = i_sts.empty ? S_REPORT : S_WALK;
                end
            end
            S_WALK: begin
                if (r_cmd == CMD_INS_TAIL) begin
                    if (i_sts.last) begin
                        o_cmd.tail_link = 1'b1;
                        n_state = S_REPORT;
                    end else begin
                        o_cmd.advance = 1'b1;
                    end
                end else if (r_cmd == CMD_DELETE) begin
                    if (i_sts.match) begin
                        o_cmd.unlink = 1'b1;
                        n_state = i_sts.prev_zero ? S_REPORT : S_RELINK;
                    end else if (i_sts.last) begin
                        n_state = S_REPORT;
                    end else begin
                        o_cmd.advance = 1'b1;
                    end
                end else if (r_cmd == CMD_SEARCH) begin
                    if (i_sts.match) begin
                        o_cmd.set_found = 1'b1;
                        n_state = S_REPORT;
                    end else if (i_sts.last) begin
                        n_state = S_REPORT;
                    end else begin
                        o_cmd.advance = 1'b1;
                    end
                end else begin
                    n_state = S_REPORT;
                end
            end
            S_RELINK: begin
                o_cmd.relink = 1'b1;
                n_state = S_REPORT;
            end
            S_REPORT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.report = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

@@ src/sll_dp.sv @@
// Node stores, list pointers and result register of the static linked list engine.
module sll_dp
    import sll_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_val                 i_operand_value,
    input  logic                 i_out_stall,
    input  t_dp_cmd              i_cmd,
    output t_dp_sts              o_sts,
    output logic                 o_out_valid,
    output logic                 o_ok,
    output logic [IDX_OUT_W-1:0] o_found_index,
    output logic [LEN_OUT_W-1:0] o_length,
    output logic                 o_empty_res,
    output logic                 o_full_res
);

    t_idx link_mem [NODE_COUNT];
    t_val val_mem  [NODE_COUNT];
    logic [NODE_COUNT-1:0] r_link_vld;

    t_idx r_head, r_free, r_cur, n_cur, r_prev, r_new, r_lnk, r_found, r_rd_raw;
    t_cnt r_count;
    t_val r_val, r_rd_val;
    logic r_rd_vld, r_ok;
    t_idx rd_link;

    logic link_we;
    t_idx link_waddr, link_wdata;

    logic                 r_out_vld, r_out_ok, r_out_empty, r_out_full;
    logic [IDX_OUT_W-1:0] r_out_found;
    logic [LEN_OUT_W-1:0] r_out_len;
    logic [WIDE_W-1:0]    found_wide, count_wide;

    assign rd_link = r_rd_vld ? r_rd_raw : reset_link(r_cur);

    always_comb begin
        if (i_cmd.start) begin
            n_cur = i_cmd.from_free ? r_free : r_head;
        end else if (i_cmd.take_tail) begin
            n_cur = r_head;
        end else if (i_cmd.advance) begin
            n_cur = rd_link;
        end else begin
            n_cur = r_cur;
        end
    end

    always_comb begin
        link_we    = 1'b1;
        link_waddr = r_cur;
        link_wdata = NODE_HEAD;
        priority if (i_cmd.take_head) begin
            link_wdata = r_head;
        end else if (i_cmd.take_tail) begin
            link_wdata = NODE_HEAD;
        end else if (i_cmd.tail_link) begin
            link_wdata = r_new;
        end else if (i_cmd.unlink) begin
            link_wdata = r_free;
        end else if (i_cmd.relink) begin
            link_waddr = r_prev;
            link_wdata = r_lnk;
        end else begin
            link_we = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (link_we) begin
            link_mem[link_waddr] <= link_wdata;
        end
        if (i_cmd.take_head || i_cmd.take_tail) begin
            val_mem[r_cur] <= r_val;
        end
        r_rd_raw <= link_mem[n_cur];
        r_rd_val <= val_mem[n_cur];
        r_rd_vld <= r_link_vld[n_cur];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_link_vld <= '0;
        end else if (link_we) begin
            r_link_vld[link_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= NODE_HEAD;
            r_free  <= NODE_FIRST;
            r_count <= '0;
            r_ok    <= 1'b0;
            r_found <= NODE_HEAD;
            r_cur   <= NODE_HEAD;
            r_prev  <= NODE_HEAD;
        end else begin
            r_cur <= n_cur;
            if (i_cmd.start) begin
                r_prev  <= NODE_HEAD;
                r_val   <= i_operand_value;
                r_found <= NODE_HEAD;
            end else if (i_cmd.advance) begin
                r_prev <= r_cur;
            end
            if (i_cmd.clear) begin
                r_head  <= NODE_HEAD;
                r_free  <= NODE_FIRST;
                r_count <= '0;
                r_ok    <= 1'b1;
            end else begin
                if (i_cmd.start) begin
                    r_ok <= 1'b0;
                end
                if (i_cmd.take_head || i_cmd.take_tail) begin
                    r_free  <= rd_link;
                    r_count <= r_count + t_cnt'(1);
                    r_ok    <= 1'b1;
                end
                if (i_cmd.take_head) begin
                    r_head <= r_cur;
                end
                if (i_cmd.take_tail) begin
                    r_new <= r_cur;
                    if (r_head == NODE_HEAD) begin
                        r_head <= r_cur;
                    end
                end
                if (i_cmd.tail_link) begin
                    r_ok <= 1'b1;
                end
                if (i_cmd.unlink) begin
                    r_free <= r_cur;
                    r_lnk  <= rd_link;
                    r_ok   <= 1'b1;
                    if (r_prev == NODE_HEAD) begin
                        r_head <= rd_link;
                    end
                    if (r_count != '0) begin
                        r_count <= r_count - t_cnt'(1);
                    end
                end
                if (i_cmd.set_found) begin
                    r_found <= r_cur;
                    r_ok    <= 1'b1;
                end
            end
        end
    end

    assign o_sts.full      = (r_free == NODE_FREE);
    assign o_sts.empty     = (r_head == NODE_HEAD);
    assign o_sts.last      = (rd_link == NODE_HEAD);
    assign o_sts.match     = (r_rd_val == r_val);
    assign o_sts.prev_zero = (r_prev == NODE_HEAD);
    assign o_sts.out_busy  = r_out_vld && i_out_stall;

    assign found_wide = WIDE_W'(r_found);
    assign count_wide = WIDE_W'(r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.report) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
        if (i_cmd.report) begin
            r_out_ok    <= r_ok;
            r_out_found <= found_wide[IDX_OUT_W-1:0];
            r_out_len   <= count_wide[LEN_OUT_W-1:0];
            r_out_empty <= (r_head == NODE_HEAD);
            r_out_full  <= (r_free == NODE_FREE);
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_ok          = r_out_ok;
    assign o_found_index = r_out_found;
    assign o_length      = r_out_len;
    assign o_empty_res   = r_out_empty;
    assign o_full_res    = r_out_full;

endmodule

@@ src/static_linked_list_engine_core.sv @@
// Top level of the static linked list engine.
//
// Input channel: i_in_valid / o_in_stall carry one command word (i_command,
// i_operand_value). Output channel: o_out_valid / i_out_stall carry one result
// word per command (o_ok, o_found_index, o_length, o_empty_res, o_full_res).
// A word moves at a clock edge with valid high and stall low.
// Commands are worked one at a time; o_in_stall is low only while idle.
// Steps after accept: clear, unused codes, inserts on a full list and deletes
// or searches on an empty list go straight to report; other inserts first
// take a free node; delete, search and a tail insert into a non-empty list
// then walk the list, one node per cycle through the single read port of the
// link store. A delete below the head adds a relink step, a second link write.
// The result sits in an output register; the next command is accepted while
// it waits, and that command finishes by holding in its report step until
// the register is free.
// Synchronous reset and the clear command both restore the initial free
// chain through per-node valid flags; no sweep is needed.
module static_linked_list_engine_core
    import sll_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [CMD_W-1:0]        i_command,
    input  logic signed [VAL_W-1:0] i_operand_value,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic                    o_ok,
    output logic [IDX_OUT_W-1:0]    o_found_index,
    output logic [LEN_OUT_W-1:0]    o_length,
    output logic                    o_empty_res,
    output logic                    o_full_res
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    sll_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_command  (i_command),
        .o_in_stall (o_in_stall),
        .o_cmd      (dp_cmd),
        .i_sts      (dp_sts)
    );

    sll_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_operand_value (t_val'(i_operand_value)),
        .i_out_stall     (i_out_stall),
        .i_cmd           (dp_cmd),
        .o_sts           (dp_sts),
        .o_out_valid     (o_out_valid),
        .o_ok            (o_ok),
        .o_found_index   (o_found_index),
        .o_length        (o_length),
        .o_empty_res     (o_empty_res),
        .o_full_res      (o_full_res)
    );

endmodule
